[hdl/terminal_escape_key_decoder_macros.svh]
// Assertion macros for the terminal escape key decoder.
`ifndef TERMINAL_ESCAPE_KEY_DECODER_MACROS_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define TEKD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be seen outside reset
`define TEKD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TEKD_ASSERT(lbl, clk, rst_n, prop, msg)
`define TEKD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[hdl/tekd_pkg.sv]
// Types, key codes and byte mapping shared by the key decoder modules.
`timescale 1ns / 1ps
package tekd_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] IDLE_LIMIT_RST = 8'd2;
  localparam int unsigned MAX_TAPS = 16;
  localparam int unsigned NTAP_W = $clog2(MAX_TAPS + 1);

  // raw bytes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] CTRL_OFS = 8'h60;

  // key codes
  localparam logic [7:0] KEY_ESC   = 8'd128;
  localparam logic [7:0] KEY_RET   = 8'd129;
  localparam logic [7:0] KEY_TAB   = 8'd130;
  localparam logic [7:0] KEY_BKSP  = 8'd131;
  localparam logic [7:0] KEY_UP    = 8'd132;
  localparam logic [7:0] KEY_DOWN  = 8'd133;
  localparam logic [7:0] KEY_RIGHT = 8'd134;
  localparam logic [7:0] KEY_LEFT  = 8'd135;
  localparam logic [7:0] KEY_HOME  = 8'd136;
  localparam logic [7:0] KEY_END   = 8'd137;
  localparam logic [7:0] KEY_INS   = 8'd138;
  localparam logic [7:0] KEY_DEL   = 8'd139;
  localparam logic [7:0] KEY_PGUP  = 8'd140;
  localparam logic [7:0] KEY_PGDN  = 8'd141;
  localparam logic [7:0] KEY_F1    = 8'd142;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       with_shift;
    logic       with_control;
    logic       last_tap;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] key;
    logic       shift;
    logic       ctrl;
  } tap_t;

  typedef struct packed {
    logic is_flush;
    tap_t tap;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EVAL,
    B_LAST
  } bstate_e;

  function automatic tap_t mk_tap(logic [7:0] key, logic shift, logic ctrl);
    tap_t t;
    t.valid = 1'b1;
    t.key   = key;
    t.shift = shift;
    t.ctrl  = ctrl;
    return t;
  endfunction

  // US layout mapping of one plain byte; valid low means no tap
  function automatic tap_t type_byte(logic [7:0] b);
    tap_t t;
    t = '0;
    if (b == CH_CR || b == CH_LF) begin
      t = mk_tap(KEY_RET, 1'b0, 1'b0);
    end else if (b == CH_TAB) begin
      t = mk_tap(KEY_TAB, 1'b0, 1'b0);
    end else if (b == CH_BS || b == CH_DEL) begin
      t = mk_tap(KEY_BKSP, 1'b0, 1'b0);
    end else if (b >= 8'd1 && b <= 8'd26) begin
      t = mk_tap(b + CTRL_OFS, 1'b0, 1'b1);
    end else if (b >= CH_UA && b <= CH_UZ) begin
      t = mk_tap(b + CASE_OFS, 1'b1, 1'b0);
    end else begin
      unique case (b)
        8'h21: t = mk_tap(8'h31, 1'b1, 1'b0); // ! 1
        8'h40: t = mk_tap(8'h32, 1'b1, 1'b0); // @ 2
        8'h23: t = mk_tap(8'h33, 1'b1, 1'b0); // # 3
        8'h24: t = mk_tap(8'h34, 1'b1, 1'b0); // $ 4
        8'h25: t = mk_tap(8'h35, 1'b1, 1'b0); // % 5
        8'h5e: t = mk_tap(8'h36, 1'b1, 1'b0); // ^ 6
        8'h26: t = mk_tap(8'h37, 1'b1, 1'b0); // & 7
        8'h2a: t = mk_tap(8'h38, 1'b1, 1'b0); // * 8
        8'h28: t = mk_tap(8'h39, 1'b1, 1'b0); // ( 9
        8'h29: t = mk_tap(8'h30, 1'b1, 1'b0); // ) 0
        8'h5f: t = mk_tap(8'h2d, 1'b1, 1'b0); // _ -
        8'h2b: t = mk_tap(8'h3d, 1'b1, 1'b0); // + =
        8'h7b: t = mk_tap(8'h5b, 1'b1, 1'b0); // { [
        8'h7d: t = mk_tap(8'h5d, 1'b1, 1'b0); // } ]
        8'h7c: t = mk_tap(8'h5c, 1'b1, 1'b0); // | backslash
        8'h3a: t = mk_tap(8'h3b, 1'b1, 1'b0); // : ;
        8'h22: t = mk_tap(8'h27, 1'b1, 1'b0); // dquote quote
        8'h7e: t = mk_tap(8'h60, 1'b1, 1'b0); // ~ backtick
        8'h3c: t = mk_tap(8'h2c, 1'b1, 1'b0); // < ,
        8'h3e: t = mk_tap(8'h2e, 1'b1, 1'b0); // > .
        8'h3f: t = mk_tap(8'h2f, 1'b1, 1'b0); // ? /
        default: begin
          if (b >= CH_SPACE && b <= CH_TILDE) begin
            t = mk_tap(b, 1'b0, 1'b0);
          end
        end
      endcase
    end
    return t;
  endfunction

endpackage

[hdl/tekd_ram.sv]
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module tekd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tekd_cmd_fifo.sv]
// Two-entry command queue between the decoder front and the tap back end.
`timescale 1ns / 1ps
module tekd_cmd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];

endmodule

[hdl/tekd_front.sv]
// Decoder front: accepts bytes and ticks, tracks the escape sequence, issues commands.
`timescale 1ns / 1ps
module tekd_front #(
  parameter int unsigned SEQ_DEPTH = 16,
  localparam int unsigned AW    = $clog2(SEQ_DEPTH),
  localparam int unsigned LEN_W = $clog2(SEQ_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tekd_pkg::in_item_t in_data_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  output logic               push_o,
  output tekd_pkg::cmd_t     cmd_o,
  output logic [LEN_W-1:0]   cmd_len_o,
  input  logic               fifo_full_i,
  input  logic               flush_done_i,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [7:0]         ram_wdata_o
);
  import tekd_pkg::*;

  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       idle_q, idle_d;
  logic [7:0]       limit_q;
  logic [7:0]       b1_q, b1_d;
  logic [7:0]       b2_q, b2_d;
  logic             busy_q, busy_d;

  logic             accept;
  logic [LEN_W-1:0] new_len;
  logic [7:0]       idle_inc;
  logic [7:0]       cur_b;
  logic             do_emit, do_flush;
  tap_t             emit_tap;
  tap_t             t_plain, t_cur, t_tilde;

  function automatic tap_t cursor_key(logic [7:0] c);
    tap_t t;
    t = '0;
    unique case (c)
      8'h41:   t = mk_tap(KEY_UP, 1'b0, 1'b0);    // A
      8'h42:   t = mk_tap(KEY_DOWN, 1'b0, 1'b0);  // B
      8'h43:   t = mk_tap(KEY_RIGHT, 1'b0, 1'b0); // C
      8'h44:   t = mk_tap(KEY_LEFT, 1'b0, 1'b0);  // D
      8'h48:   t = mk_tap(KEY_HOME, 1'b0, 1'b0);  // H
      8'h46:   t = mk_tap(KEY_END, 1'b0, 1'b0);   // F
      default: t = '0;
    endcase
    return t;
  endfunction

  // digit of ESC [ d ~
  function automatic tap_t tilde_key(logic [7:0] d);
    tap_t t;
    t = '0;
    unique case (d) inside
      8'h31, 8'h37: t = mk_tap(KEY_HOME, 1'b0, 1'b0);
      8'h32:        t = mk_tap(KEY_INS, 1'b0, 1'b0);
      8'h33:        t = mk_tap(KEY_DEL, 1'b0, 1'b0);
      8'h34, 8'h38: t = mk_tap(KEY_END, 1'b0, 1'b0);
      8'h35:        t = mk_tap(KEY_PGUP, 1'b0, 1'b0);
      8'h36:        t = mk_tap(KEY_PGDN, 1'b0, 1'b0);
      default:      t = '0;
    endcase
    return t;
  endfunction

  // a pending flush owns the byte buffer until the back end has walked it
  assign in_ready_o = !fifo_full_i && !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cur_b    = in_data_i.data_byte;
    new_len  = len_q + LEN_W'(1);
    idle_inc = (idle_q == 8'hff) ? idle_q : idle_q + 8'd1;
    t_plain  = type_byte(cur_b);
    t_cur    = cursor_key(cur_b);
    t_tilde  = tilde_key(b2_q);

    len_d     = len_q;
    idle_d    = idle_q;
    b1_d      = b1_q;
    b2_d      = b2_q;
    busy_d    = busy_q;
    do_emit   = 1'b0;
    do_flush  = 1'b0;
    emit_tap  = t_plain;
    cmd_len_o = new_len;
    ram_we_o  = 1'b0;

    if (flush_done_i) begin
      busy_d = 1'b0;
    end

    if (accept) begin
      if (in_data_i.op == OP_BYTE) begin
        if (len_q == '0) begin
          if (cur_b == CH_ESC) begin
            len_d  = LEN_W'(1);
            idle_d = '0;
          end else begin
            do_emit = t_plain.valid;
          end
        end else begin
          ram_we_o = 1'b1;
          idle_d   = '0;
          len_d    = new_len;
          if (len_q == LEN_W'(1)) begin
            b1_d = cur_b;
            if (!(cur_b == CH_LBRK || cur_b == CH_O)) begin
              do_flush = 1'b1;
            end
          end else if (len_q == LEN_W'(2)) begin
            b2_d = cur_b;
            if (t_cur.valid) begin
              do_emit  = 1'b1;
              emit_tap = t_cur;
            end else if (b1_q == CH_O) begin
              if (cur_b >= CH_P && cur_b <= CH_S) begin
                do_emit  = 1'b1;
                emit_tap = mk_tap(KEY_F1 + (cur_b - CH_P), 1'b0, 1'b0);
              end else begin
                do_flush = 1'b1;
              end
            end else if (!(cur_b >= CH_0 && cur_b <= CH_9 &&
                           new_len < LEN_W'(SEQ_DEPTH))) begin
              do_flush = 1'b1;
            end
          end else begin
            // ESC [ digit ...: waits for the tilde
            if (cur_b == CH_TILDE) begin
              if (new_len == LEN_W'(4) && t_tilde.valid) begin
                do_emit  = 1'b1;
                emit_tap = t_tilde;
              end else begin
                do_flush = 1'b1;
              end
            end else if (new_len >= LEN_W'(SEQ_DEPTH)) begin
              do_flush = 1'b1;
            end
          end
        end
      end else if (len_q != '0) begin
        idle_d    = idle_inc;
        cmd_len_o = len_q;
        if (idle_inc >= limit_q) begin
          do_flush = 1'b1;
        end
      end
    end

    if (do_emit || do_flush) begin
      len_d  = '0;
      idle_d = '0;
    end
    if (do_flush) begin
      busy_d = 1'b1;
    end

    push_o         = do_emit || do_flush;
    cmd_o.is_flush = do_flush;
    cmd_o.tap      = emit_tap;
  end

  assign ram_waddr_o = len_q[AW-1:0];
  assign ram_wdata_o = cur_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      idle_q  <= '0;
      limit_q <= IDLE_LIMIT_RST;
      busy_q  <= 1'b0;
    end else begin
      len_q  <= len_d;
      idle_q <= idle_d;
      busy_q <= busy_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q <= b1_d;
    b2_q <= b2_d;
  end

endmodule

[hdl/tekd_back.sv]
// Tap back end: plays single taps and walks flushed sequences into the output register.
`timescale 1ns / 1ps
`include "terminal_escape_key_decoder_macros.svh"
module tekd_back #(
  parameter int unsigned SEQ_DEPTH = 16,
  localparam int unsigned AW    = $clog2(SEQ_DEPTH),
  localparam int unsigned LEN_W = $clog2(SEQ_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_empty_i,
  input  tekd_pkg::cmd_t      cmd_i,
  input  logic [LEN_W-1:0]    cmd_len_i,
  output logic                pop_o,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  logic [7:0]          rd_data_i,
  output logic                flush_done_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tekd_pkg::out_item_t out_data_o
);
  import tekd_pkg::*;

  bstate_e           state_q, state_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  nxt_idx;
  logic [NTAP_W-1:0] ntaps_q, ntaps_d;
  tap_t              held_q, held_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              out_free;
  logic              produce;
  tap_t              t_byte;

  function automatic out_item_t to_out(tap_t t, logic last);
    out_item_t o;
    o.key_code     = t.key;
    o.with_shift   = t.shift;
    o.with_control = t.ctrl;
    o.last_tap     = last;
    return o;
  endfunction

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    len_d        = len_q;
    ntaps_d      = ntaps_q;
    held_d       = held_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    pop_o        = 1'b0;
    rd_en_o      = 1'b0;
    flush_done_o = 1'b0;
    nxt_idx      = (state_q == B_IDLE) ? LEN_W'(1) : idx_q + LEN_W'(1);
    t_byte       = type_byte(rd_data_i);
    produce      = t_byte.valid && (ntaps_q < NTAP_W'(MAX_TAPS));

    unique case (state_q)
      B_IDLE: begin
        if (!fifo_empty_i) begin
          if (cmd_i.is_flush) begin
            // flush opens with Escape; the walk starts at entry 1
            pop_o   = 1'b1;
            held_d  = mk_tap(KEY_ESC, 1'b0, 1'b0);
            ntaps_d = NTAP_W'(1);
            len_d   = cmd_len_i;
            idx_d   = nxt_idx;
            if (cmd_len_i > LEN_W'(1)) begin
              rd_en_o = 1'b1;
              state_d = B_EVAL;
            end else begin
              state_d = B_LAST;
            end
          end else if (out_free) begin
            pop_o       = 1'b1;
            out_valid_d = 1'b1;
            out_d       = to_out(cmd_i.tap, 1'b1);
          end
        end
      end
      B_EVAL: begin
        // one tap is held back so the last one can be marked
        if (!produce || out_free) begin
          if (produce) begin
            out_valid_d = 1'b1;
            out_d       = to_out(held_q, 1'b0);
            held_d      = t_byte;
            ntaps_d     = ntaps_q + NTAP_W'(1);
          end
          if (nxt_idx < len_q) begin
            rd_en_o = 1'b1;
            idx_d   = nxt_idx;
          end else begin
            state_d = B_LAST;
          end
        end
      end
      B_LAST: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = to_out(held_q, 1'b1);
          flush_done_o = 1'b1;
          state_d      = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign rd_addr_o = nxt_idx[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      ntaps_q     <= '0;
      idx_q       <= '0;
      len_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ntaps_q     <= ntaps_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TEKD_ASSERT(a_eval_idx, clk_i, rst_ni, (state_q == B_EVAL) |-> (idx_q != '0 && idx_q < len_q), "walk index outside sequence")
  `TEKD_ASSERT_NEVER(a_tap_cap, clk_i, rst_ni, ntaps_q > NTAP_W'(MAX_TAPS), "tap count above cap")
  `TEKD_ASSERT(a_last_out, clk_i, rst_ni, (state_q == B_LAST && out_free) |=> (out_valid_q && out_q.last_tap && state_q == B_IDLE), "flush end not marked last")
  `TEKD_ASSERT_NEVER(a_pop_busy, clk_i, rst_ni, pop_o && state_q != B_IDLE, "command taken during a flush")

endmodule

[hdl/terminal_escape_key_decoder.sv]
// Top level of the terminal escape key decoder: front, command queue, byte buffer, back end.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_ready_o   | in_data_i  (op, data_byte)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (key_code, shift, ctrl, last)
//   cfg     | input     | cfg_we_i                  | cfg_wdata_i (idle_limit)
//
// A byte or tick is taken on the in handshake. A plain tap or decoded key enters the output
// register at the edge that pops it from the command queue. A flush walks the byte buffer
// through its registered read port, one buffered byte a cycle while no tap waits on a stalled
// output, and the flush ends with the held tap sent out marked last.
// in_ready_o stays low while the queue is full or a flush is queued or being walked.
// Reset clears length, idle count, queue and output; idle_limit returns to 2; buffer kept.
`timescale 1ns / 1ps
module terminal_escape_key_decoder #(
  parameter int unsigned SEQ_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tekd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tekd_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);
  import tekd_pkg::*;

  localparam int unsigned AW    = $clog2(SEQ_DEPTH);
  localparam int unsigned LEN_W = $clog2(SEQ_DEPTH + 1);
  localparam int unsigned QW    = $bits(cmd_t) + LEN_W;

  // front -> queue
  logic             f_push;
  cmd_t             f_cmd;
  logic [LEN_W-1:0] f_len;
  logic             q_full;
  logic [QW-1:0]    q_wdata;

  // queue -> back
  logic             q_empty;
  logic             b_pop;
  logic [QW-1:0]    q_rdata;
  cmd_t             b_cmd;
  logic [LEN_W-1:0] b_len;

  // byte buffer ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  logic             flush_done;

  assign q_wdata        = {f_cmd, f_len};
  assign {b_cmd, b_len} = q_rdata;

  tekd_front #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_o       (f_push),
    .cmd_o        (f_cmd),
    .cmd_len_o    (f_len),
    .fifo_full_i  (q_full),
    .flush_done_i (flush_done),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  tekd_cmd_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // escape sequence bytes, written by the front, walked by the back end
  tekd_ram #(
    .WIDTH (8),
    .DEPTH (SEQ_DEPTH)
  ) u_seq_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tekd_back #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (q_empty),
    .cmd_i        (b_cmd),
    .cmd_len_i    (b_len),
    .pop_o        (b_pop),
    .rd_en_o      (ram_re),
    .rd_addr_o    (ram_raddr),
    .rd_data_i    (ram_rdata),
    .flush_done_o (flush_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
